/* rtl/core/brts_pkg.sv */
// Package for the BLE reply timeout supervisor: message-kind codes, role and
// action codes, and the single-pass decision function. No dependencies.
package brts_pkg;

   typedef logic [4:0] kind_type;
   typedef logic [1:0] action_type;

   // Message-kind codes that the decision logic names.
   localparam kind_type K_UNKNOWN                 = 5'd0;
   localparam kind_type K_BUSY                    = 5'd1;
   localparam kind_type K_GENERAL_ERROR           = 5'd2;
   localparam kind_type K_AP_REQUEST              = 5'd3;
   localparam kind_type K_AP_RESPONSE             = 5'd4;
   localparam kind_type K_SETUP_M1                = 5'd5;
   localparam kind_type K_SETUP_M2                = 5'd6;
   localparam kind_type K_SETUP_M3                = 5'd7;
   localparam kind_type K_SETUP_M4                = 5'd8;
   localparam kind_type K_SUSPEND_REQUEST         = 5'd9;
   localparam kind_type K_SUSPEND_RESPONSE        = 5'd10;
   localparam kind_type K_RESUME_REQUEST          = 5'd11;
   localparam kind_type K_RESUME_RESPONSE         = 5'd12;
   localparam kind_type K_ACCESS_COMPLETED        = 5'd14;
   localparam kind_type K_INITIATE_ACCESS         = 5'd16;
   localparam kind_type K_INITIATE_ACCESS_RKE     = 5'd17;
   localparam kind_type K_INITIATE_RANGING        = 5'd18;
   localparam kind_type K_INITIATE_RANGING_RESUME = 5'd19;
   localparam kind_type K_SETUP_LATER             = 5'd20;
   localparam kind_type K_RESUME_LATER            = 5'd21;

   // Timer actions.
   localparam action_type ACT_NONE      = 2'd0;
   localparam action_type ACT_ARM       = 2'd1;
   localparam action_type ACT_STOP      = 2'd2;
   localparam action_type ACT_TERMINATE = 2'd3;

   // Who is waiting for a reply.
   typedef enum logic [2:0] {
      ROLE_IDLE = 3'b001,
      ROLE_TX   = 3'b010,
      ROLE_RX   = 3'b100
   } role_type;

   // Outcome of one observed message.
   typedef struct packed {
      action_type action;
      role_type   role;
      kind_type   pending;
   } decision_type;

   function automatic logic expects_reply(kind_type k);
      logic r;
      case (k)
         K_INITIATE_ACCESS, K_INITIATE_ACCESS_RKE, K_AP_REQUEST, K_AP_RESPONSE,
         K_INITIATE_RANGING, K_SETUP_M1, K_SETUP_M2, K_SETUP_M3,
         K_SUSPEND_REQUEST, K_INITIATE_RANGING_RESUME, K_RESUME_REQUEST: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   // Busy and general error are handled before this is consulted.
   function automatic logic reply_fits(kind_type req, kind_type rep);
      logic r;
      case (req)
         K_INITIATE_ACCESS, K_INITIATE_ACCESS_RKE: r = (rep == K_AP_REQUEST);
         K_AP_REQUEST:       r = (rep == K_AP_RESPONSE);
         K_AP_RESPONSE:      r = (rep == K_AP_REQUEST) || (rep == K_ACCESS_COMPLETED);
         K_INITIATE_RANGING: r = (rep == K_SETUP_M1) || (rep == K_SETUP_LATER);
         K_SETUP_M1:         r = (rep == K_SETUP_M2) || (rep == K_SETUP_LATER);
         K_SETUP_M2:         r = (rep == K_SETUP_M3);
         K_SETUP_M3:         r = (rep == K_SETUP_M4);
         K_SUSPEND_REQUEST:  r = (rep == K_SUSPEND_RESPONSE);
         K_INITIATE_RANGING_RESUME:
            r = (rep == K_RESUME_REQUEST) || (rep == K_RESUME_LATER);
         K_RESUME_REQUEST:   r = (rep == K_RESUME_RESPONSE) || (rep == K_RESUME_LATER);
         default:            r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic displaces(kind_type pend, kind_type inc);
      logic pend_ok;
      logic inc_ok;
      pend_ok = (pend == K_RESUME_REQUEST) || (pend == K_SUSPEND_REQUEST);
      inc_ok  = (inc == K_INITIATE_RANGING) || (inc == K_INITIATE_RANGING_RESUME) ||
                (inc == K_SUSPEND_REQUEST);
      return pend_ok && inc_ok;
   endfunction

   function automatic decision_type decide(logic outgoing, kind_type k,
                                           role_type role, kind_type pend);
      decision_type d;
      logic back_to_tx;
      logic back_to_rx;
      logic reply_dir;
      role_type new_role;
      back_to_tx = !outgoing && (role == ROLE_TX);
      back_to_rx = outgoing && (role == ROLE_RX);
      reply_dir  = back_to_tx || back_to_rx;
      new_role   = outgoing ? ROLE_TX : ROLE_RX;
      d.action   = ACT_NONE;
      d.role     = role;
      d.pending  = pend;
      if (k == K_BUSY) begin
         d.action = reply_dir ? ACT_ARM : ACT_NONE;
      end else if (k == K_GENERAL_ERROR) begin
         if (reply_dir) begin
            d.action  = back_to_tx ? ACT_TERMINATE : ACT_STOP;
            d.role    = ROLE_IDLE;
            d.pending = K_UNKNOWN;
         end
      end else if (role != ROLE_IDLE) begin
         if (reply_dir && reply_fits(pend, k)) begin
            if (expects_reply(k)) begin
               d.action  = ACT_ARM;
               d.role    = new_role;
               d.pending = k;
            end else begin
               d.action  = ACT_STOP;
               d.role    = ROLE_IDLE;
               d.pending = K_UNKNOWN;
            end
         end else if (back_to_tx && displaces(pend, k)) begin
            d.action  = ACT_ARM;
            d.role    = new_role;
            d.pending = k;
         end
      end else if (expects_reply(k)) begin
         d.action  = ACT_ARM;
         d.role    = new_role;
         d.pending = k;
      end
      return d;
   endfunction

endpackage

/* rtl/core/ble_reply_timeout_supervisor.sv */
// Top level of the BLE reply timeout supervisor: input register, role and
// pending-request state, and result register. Depends on brts_pkg.
//
// Usage:
//   The req_ channel carries one observed link message per transfer: its
//   direction (0 incoming from the phone, 1 outgoing from the local side)
//   and its message-kind code. For every transfer on req_ the block delivers
//   exactly one transfer on rsp_ that carries the timer action: none, arm,
//   stop or terminate the connection.
//   A message taken from req_ lands in the input register; the decision is
//   made and the role state updated as it passes into the result register,
//   whose content is shown on rsp_. While rsp_stall is low the block takes
//   one message per cycle; the decision is a single pass of short logic
//   between the input register and the result register.
//   When the receiver raises rsp_stall the result register holds its value,
//   the input register keeps one more message, and only then is req_stall
//   raised; req_stall follows rsp_stall in the same cycle and never rises
//   while rsp_stall is low.
//   Synchronous reset empties both registers, returns the role to idle and
//   clears the pending request kind to unknown.
module ble_reply_timeout_supervisor (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_direction,
   input  logic [4:0] req_message_kind,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_action
);

   // Input register.
   logic                 in_valid_ff, in_valid_in;
   logic                 in_dir_ff;
   brts_pkg::kind_type   in_kind_ff;

   // Supervisor state.
   brts_pkg::role_type   role_ff;
   brts_pkg::kind_type   pending_ff;

   // Result register.
   logic                 out_valid_ff, out_valid_in;
   brts_pkg::action_type out_action_ff;

   logic                   advance;
   logic                   req_take;
   brts_pkg::decision_type dec;

   // The result register can take a new value when it is empty or being
   // drained in this cycle.
   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign dec = brts_pkg::decide(in_dir_ff, in_kind_ff, role_ff, pending_ff);

   assign in_valid_in  = (advance || !in_valid_ff) ? req_valid : 1'b1;
   assign out_valid_in = advance ? in_valid_ff : 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         role_ff      <= brts_pkg::ROLE_IDLE;
         pending_ff   <= brts_pkg::K_UNKNOWN;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         // State moves only when a message passes into the result register,
         // so every message sees the state left by the one before it.
         if (advance && in_valid_ff) begin
            role_ff    <= dec.role;
            pending_ff <= dec.pending;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_dir_ff  <= req_direction;
         in_kind_ff <= req_message_kind;
      end
      if (advance && in_valid_ff) begin
         out_action_ff <= dec.action;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_action = out_action_ff;

endmodule

/* rtl/core/brts_checker.sv */
// Port-level checker for the BLE reply timeout supervisor, bound to the top
// level. It has no package dependencies.
module brts_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [4:0] req_message_kind,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_action
);

   // A stalled result keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_action))
      else $error("stalled result changed");

   // Reset empties the result register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Back pressure only passes through from the result side.
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input stalled while result side is free");

   // A new result traces back to an earlier transfer on the input side.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result without a matching input transfer");

   // A stalled message keeps valid and its kind on the input ports until it is taken.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_message_kind))
      else $error("stalled input message changed");

endmodule

bind ble_reply_timeout_supervisor brts_checker u_brts_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_message_kind (req_message_kind),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_action       (rsp_action)
);

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for ble_reply_timeout_supervisor: directed and random
// message streams checked against a local model of the reply protocol.
// Depends on brts_pkg and the ble_reply_timeout_supervisor RTL.
module tb_top;
   import brts_pkg::*;

   // Kind codes used here that the package leaves unnamed.
   localparam kind_type K_PASS_THROUGH = 5'd25;
   localparam kind_type K_TOP_CODE     = 5'd31;

   localparam int RANDOM_MESSAGES = 950;
   // Sender gaps and random receiver stalls stop for the last stretch of the random stream.
   localparam int QUIET_TAIL      = 150;
   // Sent-message count at which the receiver holds off for a long stretch.
   localparam int HOLD_AT         = 300;
   localparam int HOLD_CYCLES     = 60;
   localparam int MAX_REPORTS     = 10;

   // One row of the directed stream. Where fixed is set, act is the action
   // typed in by hand; otherwise the local model supplies the expectation.
   typedef struct packed {
      logic       dir;
      kind_type   kind;
      logic       fixed;
      action_type act;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 23;
   localparam stim_row_type DIRECTED [0:DIRECTED_ROWS-1] = '{
      // Busy, general error and unknown codes while idle do nothing.
      '{1'b1, K_BUSY,                    1'b1, ACT_NONE},
      '{1'b0, K_GENERAL_ERROR,           1'b1, ACT_NONE},
      '{1'b0, K_TOP_CODE,                1'b1, ACT_NONE},
      '{1'b0, K_UNKNOWN,                 1'b1, ACT_NONE},
      // Access exchange: a request from the idle state arms the timer.
      '{1'b1, K_INITIATE_ACCESS,         1'b1, ACT_ARM},
      '{1'b0, K_BUSY,                    1'b1, ACT_ARM},
      '{1'b1, K_BUSY,                    1'b1, ACT_NONE},
      '{1'b0, K_AP_REQUEST,              1'b0, ACT_NONE},
      '{1'b1, K_AP_RESPONSE,             1'b0, ACT_NONE},
      '{1'b0, K_ACCESS_COMPLETED,        1'b0, ACT_NONE},
      // General error answering each side.
      '{1'b1, K_INITIATE_RANGING,        1'b0, ACT_NONE},
      '{1'b0, K_GENERAL_ERROR,           1'b1, ACT_TERMINATE},
      '{1'b0, K_INITIATE_RANGING,        1'b0, ACT_NONE},
      '{1'b1, K_GENERAL_ERROR,           1'b1, ACT_STOP},
      // Incoming requests displacing a local suspend or resume request.
      '{1'b1, K_SUSPEND_REQUEST,         1'b0, ACT_NONE},
      '{1'b0, K_INITIATE_RANGING_RESUME, 1'b0, ACT_NONE},
      '{1'b1, K_RESUME_LATER,            1'b0, ACT_NONE},
      '{1'b1, K_RESUME_REQUEST,          1'b0, ACT_NONE},
      '{1'b0, K_SUSPEND_REQUEST,         1'b0, ACT_NONE},
      '{1'b1, K_SUSPEND_RESPONSE,        1'b0, ACT_NONE},
      // A kind that never expects a reply, then a ranging setup put off.
      '{1'b0, K_PASS_THROUGH,            1'b1, ACT_NONE},
      '{1'b1, K_SETUP_M1,                1'b0, ACT_NONE},
      '{1'b0, K_SETUP_LATER,             1'b0, ACT_NONE}
   };

   // Kinds that open an exchange, and incoming kinds that can displace a
   // pending suspend or resume request.
   localparam kind_type OPENERS [0:10] = '{
      K_INITIATE_ACCESS, K_INITIATE_ACCESS_RKE, K_AP_REQUEST, K_AP_RESPONSE,
      K_INITIATE_RANGING, K_SETUP_M1, K_SETUP_M2, K_SETUP_M3,
      K_SUSPEND_REQUEST, K_INITIATE_RANGING_RESUME, K_RESUME_REQUEST
   };
   localparam kind_type DISPLACERS [0:2] = '{
      K_INITIATE_RANGING, K_INITIATE_RANGING_RESUME, K_SUSPEND_REQUEST
   };

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic       req_direction;
   logic [4:0] req_message_kind;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [1:0] rsp_action;

   // Local copy of the supervisor state.
   role_type   link_role;
   kind_type   open_request;

   // Timer actions still owed by the block, oldest first.
   action_type expected_actions [$];

   int         error_count;
   int         msgs_sent;
   logic       gaps_on;
   logic       hold_done;

   ble_reply_timeout_supervisor i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_direction    (req_direction),
      .req_message_kind (req_message_kind),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_action       (rsp_action)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // True for request kinds that wait for an answer from the other side.
   function automatic logic awaits_answer(kind_type k);
      case (k)
         K_INITIATE_ACCESS, K_INITIATE_ACCESS_RKE, K_AP_REQUEST, K_AP_RESPONSE,
         K_INITIATE_RANGING, K_SETUP_M1, K_SETUP_M2, K_SETUP_M3,
         K_SUSPEND_REQUEST, K_INITIATE_RANGING_RESUME, K_RESUME_REQUEST:
            return 1'b1;
         default:
            return 1'b0;
      endcase
   endfunction

   // True when rep is an acceptable answer to the outstanding request req.
   // Busy and general error are sorted out before this is asked.
   function automatic logic answer_allowed(kind_type req, kind_type rep);
      case (req)
         K_INITIATE_ACCESS, K_INITIATE_ACCESS_RKE: return rep == K_AP_REQUEST;
         K_AP_REQUEST:       return rep == K_AP_RESPONSE;
         K_AP_RESPONSE:      return rep == K_AP_REQUEST || rep == K_ACCESS_COMPLETED;
         K_INITIATE_RANGING: return rep == K_SETUP_M1 || rep == K_SETUP_LATER;
         K_SETUP_M1:         return rep == K_SETUP_M2 || rep == K_SETUP_LATER;
         K_SETUP_M2:         return rep == K_SETUP_M3;
         K_SETUP_M3:         return rep == K_SETUP_M4;
         K_SUSPEND_REQUEST:  return rep == K_SUSPEND_RESPONSE;
         K_INITIATE_RANGING_RESUME:
            return rep == K_RESUME_REQUEST || rep == K_RESUME_LATER;
         K_RESUME_REQUEST:   return rep == K_RESUME_RESPONSE || rep == K_RESUME_LATER;
         default:            return 1'b0;
      endcase
   endfunction

   // Advances the local supervisor state by one observed message and returns
   // the timer action that the block must produce for it.
   function automatic action_type advance_link(logic outgoing, kind_type k);
      logic     answer_to_tx;
      logic     answer_to_rx;
      logic     answer_dir;
      logic     preempts;
      role_type sender_role;
      answer_to_tx = !outgoing && link_role == ROLE_TX;
      answer_to_rx = outgoing && link_role == ROLE_RX;
      answer_dir   = answer_to_tx || answer_to_rx;
      sender_role  = outgoing ? ROLE_TX : ROLE_RX;
      preempts     = (open_request == K_SUSPEND_REQUEST ||
                      open_request == K_RESUME_REQUEST) &&
                     (k == K_INITIATE_RANGING || k == K_INITIATE_RANGING_RESUME ||
                      k == K_SUSPEND_REQUEST);

      // Busy only keeps the timer alive, and only on the answering side.
      if (k == K_BUSY) begin
         return answer_dir ? ACT_ARM : ACT_NONE;
      end
      // General error from the answering side ends the exchange: the connection is torn down when the
      // local side asked, and the timer is merely stopped when the phone asked.
      if (k == K_GENERAL_ERROR) begin
         if (!answer_dir) begin
            return ACT_NONE;
         end
         link_role    = ROLE_IDLE;
         open_request = K_UNKNOWN;
         return answer_to_tx ? ACT_TERMINATE : ACT_STOP;
      end
      if (link_role != ROLE_IDLE) begin
         if (answer_dir && answer_allowed(open_request, k)) begin
            if (awaits_answer(k)) begin
               link_role    = sender_role;
               open_request = k;
               return ACT_ARM;
            end
            link_role    = ROLE_IDLE;
            open_request = K_UNKNOWN;
            return ACT_STOP;
         end
         if (answer_to_tx && preempts) begin
            link_role    = sender_role;
            open_request = k;
            return ACT_ARM;
         end
         return ACT_NONE;
      end
      // Idle: a message that wants an answer starts a new exchange.
      if (awaits_answer(k)) begin
         link_role    = sender_role;
         open_request = k;
         return ACT_ARM;
      end
      return ACT_NONE;
   endfunction

   // Offers one message on the request channel and returns at the rising edge
   // at which the transfer takes place. Valid is held steady while stalled.
   task automatic send_message(input logic dir, input kind_type kind);
      @(negedge clock);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_direction    <= dir;
      req_message_kind <= kind;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      msgs_sent++;
   endtask

   // Stimulus: reset, the directed table, then the random stream.
   initial begin
      stim_row_type row;
      action_type   predicted;
      logic         dir;
      kind_type     kind;
      int           pick;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_direction    = 1'b0;
      req_message_kind = '0;
      link_role        = ROLE_IDLE;
      open_request     = K_UNKNOWN;
      error_count      = 0;
      msgs_sent        = 0;
      gaps_on          = 1'b1;
      hold_done        = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         row       = DIRECTED[i];
         predicted = advance_link(row.dir, row.kind);
         expected_actions.push_back(row.fixed ? row.act : predicted);
         send_message(row.dir, row.kind);
      end

      // Most random messages follow the protocol so that long exchanges are
      // reached; the rest are arbitrary codes in either direction.
      for (int n = 0; n < RANDOM_MESSAGES; n++) begin
         if (n == RANDOM_MESSAGES - QUIET_TAIL) begin
            gaps_on = 1'b0;
         end
         pick = $urandom_range(0, 99);
         if (pick >= 70) begin
            dir  = 1'($urandom_range(0, 1));
            kind = kind_type'($urandom_range(0, 31));
         end else if (link_role == ROLE_IDLE) begin
            dir  = 1'($urandom_range(0, 1));
            kind = OPENERS[$urandom_range(0, 10)];
         end else begin
            // Answer from the side that is expected to reply.
            dir = (link_role == ROLE_RX);
            if (pick < 7) begin
               kind = K_BUSY;
            end else if (pick < 11) begin
               kind = K_GENERAL_ERROR;
            end else if (pick < 17) begin
               dir  = 1'b0;
               kind = DISPLACERS[$urandom_range(0, 2)];
            end else begin
               case (open_request)
                  K_INITIATE_ACCESS, K_INITIATE_ACCESS_RKE: kind = K_AP_REQUEST;
                  K_AP_REQUEST: kind = K_AP_RESPONSE;
                  K_AP_RESPONSE:
                     kind = $urandom_range(0, 3) != 0 ? K_AP_REQUEST : K_ACCESS_COMPLETED;
                  K_INITIATE_RANGING:
                     kind = $urandom_range(0, 3) != 0 ? K_SETUP_M1 : K_SETUP_LATER;
                  K_SETUP_M1:
                     kind = $urandom_range(0, 3) != 0 ? K_SETUP_M2 : K_SETUP_LATER;
                  K_SETUP_M2: kind = K_SETUP_M3;
                  K_SETUP_M3: kind = K_SETUP_M4;
                  K_SUSPEND_REQUEST: kind = K_SUSPEND_RESPONSE;
                  K_INITIATE_RANGING_RESUME:
                     kind = $urandom_range(0, 3) != 0 ? K_RESUME_REQUEST : K_RESUME_LATER;
                  K_RESUME_REQUEST:
                     kind = $urandom_range(0, 1) != 0 ? K_RESUME_RESPONSE : K_RESUME_LATER;
                  default: kind = kind_type'($urandom_range(0, 31));
               endcase
            end
         end
         expected_actions.push_back(advance_link(dir, kind));
         send_message(dir, kind);
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_actions.size() != 0) @(posedge clock);
      // Keep watching to catch any result the block should not produce.
      repeat (8) @(posedge clock);
      if (error_count == 0 && expected_actions.size() == 0) begin
         $display("ble_reply_timeout_supervisor verification clean");
      end else begin
         $display("ble_reply_timeout_supervisor verification failed");
      end
      $finish;
   end

   // Receiver: short random stall bursts while idling is enabled, and one long
   // hold-off so that both internal registers fill and req_stall rises.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && msgs_sent >= HOLD_AT) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            for (int c = 0; c < HOLD_CYCLES; c++) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if (gaps_on && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 6)) @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Each result transfer is matched against the oldest outstanding action.
   always @(posedge clock) begin : check_results
      action_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_actions.size() == 0) begin
            if (error_count < MAX_REPORTS) begin
               $display("[%0t] unexpected result transfer: action %0d", $realtime,
                        rsp_action);
            end
            error_count++;
         end else begin
            want = expected_actions.pop_front();
            if (rsp_action !== want) begin
               if (error_count < MAX_REPORTS) begin
                  $display("[%0t] action mismatch: expected %0d, got %0d", $realtime,
                           want, rsp_action);
               end
               error_count++;
            end
         end
      end
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #3000000;
      $display("ble_reply_timeout_supervisor verification failed");
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/brts_pkg.sv
rtl/core/ble_reply_timeout_supervisor.sv
rtl/core/brts_checker.sv
tb/tb_top.sv
